// ----- rtl/core/sha1he_pkg.sv -----
// ============================================================================
// sha1he_pkg
// Shared types and constants for the SHA-1 hash engine: beat structs, the
// micro-op and jump-condition codes, and the sequencer status struct.
// ============================================================================
package sha1he_pkg;

    // Round constants
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Initial chaining value, H_INIT[0] is H0
    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [2:0] MAX_BYTES   = 3'd4;
    localparam logic [2:0] DIGEST_LAST = 3'd4;
    localparam logic [6:0] ROUND_LAST  = 7'd79;

    // Input beat: up to four message bytes, first byte in bits 31..24
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_in;
    } t_in_beat;

    // Output beat: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_out;
    } t_out_beat;

    // Datapath micro-ops
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_ABSORB,
        OP_PAD,
        OP_LEN,
        OP_LOAD,
        OP_ROUND,
        OP_FOLD,
        OP_EMIT,
        OP_DRAIN,
        OP_NEXTW,
        OP_REINIT
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_ACC,
        C_FULL,
        C_NOT_LAST,
        C_LEN_DONE,
        C_PAD_DONE,
        C_RND_MORE,
        C_MORE,
        C_OUT_ACC,
        C_IDX_MORE
    } t_cond;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_acc;
        logic full;
        logic not_last;
        logic len_done;
        logic pad_done;
        logic rnd_more;
        logic more;
        logic out_acc;
        logic idx_more;
    } t_seq_flags;

endpackage

// ----- rtl/core/sha1_hash_engine.sv -----
// ============================================================================
// sha1_hash_engine
// Streaming SHA-1: packs message bytes into a 64-byte block, compresses one
// round per cycle, pads on the last beat and returns the five digest words.
// ============================================================================
// Usage: each input beat carries 0..4 message bytes (first byte in bits
// 31..24, counts above four act as four) and a last flag. The engine handles
// one beat at a time: a beat that does not complete a block is accepted,
// merged and routed. Completing a 64-byte block adds the compression (load,
// 80 rounds on the single round unit, fold, one routing step).
// The last beat adds padding and one or two compressions, then the digest
// goes out as five beats, H0 first, each one emitted, held while the output
// stalls and followed by an index step; after the fifth word the engine
// returns to the initial vector and a zero bit count on its own. Input stall
// is high whenever the engine is busy.
module sha1_hash_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sha1he_pkg::t_in_beat i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sha1he_pkg::t_out_beat o_out_beat
);

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

    sha1he_pkg::t_op        op;
    sha1he_pkg::t_seq_flags flags;

    // Datapath state
    logic [31:0] r_h   [5];
    logic [31:0] n_h   [5];
    logic [31:0] r_blk [16];
    logic [31:0] n_blk [16];
    logic [63:0] r_bits, n_bits;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [6:0]  r_rnd, n_rnd;
    logic [31:0] r_data, n_data;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic        r_pad_done, n_pad_done;
    logic        r_len_done, n_len_done;
    logic [2:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    sha1he_pkg::t_out_beat r_out, n_out;

    // Derived values
    logic        in_acc, out_acc;
    logic [5:0]  pos;
    logic [6:0]  room;
    logic [2:0]  take_n;
    logic        full;
    logic [2:0]  clamp_cnt;
    logic [31:0] f_val, k_val, tmp, w_new, w_x;

    assign in_acc  = (op == sha1he_pkg::OP_WAIT) && i_in_valid;
    assign out_acc = r_out_valid && !i_out_stall;

    assign o_in_stall  = (op != sha1he_pkg::OP_WAIT);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Byte position within the block and how much of the beat fits
    assign pos       = r_bits[8:3];
    assign room      = 7'd64 - {1'b0, pos};
    assign take_n    = (7'(r_cnt) < room) ? r_cnt : room[2:0];
    assign full      = ({1'b0, pos} + 7'(take_n)) == 7'd64;
    assign clamp_cnt = (i_in_beat.byte_count > sha1he_pkg::MAX_BYTES) ?
                       sha1he_pkg::MAX_BYTES : i_in_beat.byte_count;

    // Round function and message schedule
    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1he_pkg::K0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1he_pkg::K1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1he_pkg::K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1he_pkg::K3;
        end
        tmp   = rotl5(r_a) + f_val + r_e + k_val + r_blk[0];
        w_x   = r_blk[13] ^ r_blk[8] ^ r_blk[2] ^ r_blk[0];
        w_new = rotl1(w_x);
    end

    // Sequencer status
    always_comb begin
        flags.in_acc   = in_acc;
        flags.full     = full;
        flags.not_last = !r_last;
        flags.len_done = r_len_done;
        flags.pad_done = r_pad_done;
        flags.rnd_more = (r_rnd != sha1he_pkg::ROUND_LAST);
        flags.more     = (r_cnt != 3'd0);
        flags.out_acc  = out_acc;
        flags.idx_more = (r_idx != sha1he_pkg::DIGEST_LAST);
    end

    sha1he_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op)
    );

    // Datapath next state, one micro-op per cycle
    always_comb begin
        logic [5:0] off;
        logic [5:0] p;
        n_h         = r_h;
        n_blk       = r_blk;
        n_bits      = r_bits;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_e         = r_e;
        n_rnd       = r_rnd;
        n_data      = r_data;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_pad_done  = r_pad_done;
        n_len_done  = r_len_done;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        off         = 6'd0;
        p           = 6'd0;
        case (op)
            sha1he_pkg::OP_WAIT: begin
                if (in_acc) begin
                    n_data = i_in_beat.data_word;
                    n_cnt  = clamp_cnt;
                    n_last = i_in_beat.last_in;
                end
            end
            sha1he_pkg::OP_ABSORB: begin
                // merge the bytes that fit into the block
                for (int w = 0; w < 16; w++) begin
                    for (int b = 0; b < 4; b++) begin
                        p   = 6'(w * 4 + b);
                        off = p - pos;
                        if (off < 6'(take_n)) begin
                            n_blk[w][8*(3-b) +: 8] =
                                8'(r_data >> (5'd24 - {off[1:0], 3'b000}));
                        end
                    end
                end
                n_bits = r_bits + 64'({take_n, 3'b000});
                n_cnt  = r_cnt - take_n;
                n_data = r_data << {take_n, 3'b000};
            end
            sha1he_pkg::OP_PAD: begin
                // pad byte, zero fill, and the length if it still fits
                for (int w = 0; w < 16; w++) begin
                    for (int b = 0; b < 4; b++) begin
                        p = 6'(w * 4 + b);
                        if (p == pos) begin
                            n_blk[w][8*(3-b) +: 8] = sha1he_pkg::PAD_BYTE;
                        end else if (p > pos) begin
                            n_blk[w][8*(3-b) +: 8] = 8'h00;
                        end
                    end
                end
                if (pos < 6'd56) begin
                    n_blk[14]  = r_bits[63:32];
                    n_blk[15]  = r_bits[31:0];
                    n_len_done = 1'b1;
                end
                n_pad_done = 1'b1;
            end
            sha1he_pkg::OP_LEN: begin
                // extra block: zeros then the length
                for (int w = 0; w < 14; w++) begin
                    n_blk[w] = 32'h0;
                end
                n_blk[14]  = r_bits[63:32];
                n_blk[15]  = r_bits[31:0];
                n_len_done = 1'b1;
            end
            sha1he_pkg::OP_LOAD: begin
                n_a   = r_h[0];
                n_b   = r_h[1];
                n_c   = r_h[2];
                n_d   = r_h[3];
                n_e   = r_h[4];
                n_rnd = 7'd0;
            end
            sha1he_pkg::OP_ROUND: begin
                n_a = tmp;
                n_b = r_a;
                n_c = rotl30(r_b);
                n_d = r_c;
                n_e = r_d;
                // schedule window slides by one word
                for (int w = 0; w < 15; w++) begin
                    n_blk[w] = r_blk[w+1];
                end
                n_blk[15] = w_new;
                n_rnd     = r_rnd + 7'd1;
            end
            sha1he_pkg::OP_FOLD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                n_h[4] = r_h[4] + r_e;
            end
            sha1he_pkg::OP_EMIT: begin
                n_out.digest_word = r_h[r_idx];
                n_out.word_index  = r_idx;
                n_out.last_out    = (r_idx == sha1he_pkg::DIGEST_LAST);
                n_out_valid       = 1'b1;
            end
            sha1he_pkg::OP_DRAIN: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                end
            end
            sha1he_pkg::OP_NEXTW: begin
                n_idx = r_idx + 3'd1;
            end
            sha1he_pkg::OP_REINIT: begin
                for (int i = 0; i < 5; i++) begin
                    n_h[i] = sha1he_pkg::H_INIT[i];
                end
                n_bits     = 64'd0;
                n_pad_done = 1'b0;
                n_len_done = 1'b0;
                n_idx      = 3'd0;
            end
            default: begin
            end
        endcase
    end

    // Control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1he_pkg::H_INIT[i];
            end
            r_bits      <= 64'd0;
            r_rnd       <= 7'd0;
            r_cnt       <= 3'd0;
            r_last      <= 1'b0;
            r_pad_done  <= 1'b0;
            r_len_done  <= 1'b0;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_h         <= n_h;
            r_bits      <= n_bits;
            r_rnd       <= n_rnd;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_pad_done  <= n_pad_done;
            r_len_done  <= n_len_done;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_e    <= n_e;
        r_data <= n_data;
        r_out  <= n_out;
    end

endmodule

// ----- rtl/core/sha1he_useq.sv -----
// ============================================================================
// sha1he_useq
// Microcode sequencer: a step counter walks a read-only program; each control
// word carries a micro-op, a jump condition and the two successor steps.
// ============================================================================
module sha1he_useq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha1he_pkg::t_seq_flags i_flags,
    output sha1he_pkg::t_op        o_op
);

    // Program addresses
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ABSORB  = 4'd1;
    localparam logic [3:0] S_RT_LAST = 4'd2;
    localparam logic [3:0] S_RT_LEN  = 4'd3;
    localparam logic [3:0] S_RT_PAD  = 4'd4;
    localparam logic [3:0] S_PAD     = 4'd5;
    localparam logic [3:0] S_LEN     = 4'd6;
    localparam logic [3:0] S_LOAD    = 4'd7;
    localparam logic [3:0] S_ROUND   = 4'd8;
    localparam logic [3:0] S_FOLD    = 4'd9;
    localparam logic [3:0] S_RT_MORE = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;
    localparam logic [3:0] S_DRAIN   = 4'd12;
    localparam logic [3:0] S_NEXTW   = 4'd13;
    localparam logic [3:0] S_FINISH  = 4'd14;

    typedef struct packed {
        sha1he_pkg::t_op   op;
        sha1he_pkg::t_cond cond;
        logic [3:0]        jmp;   // taken when cond holds
        logic [3:0]        nxt;   // taken otherwise
    } t_ucode;

    // Control store
    function automatic t_ucode ucode_rom(input logic [3:0] step);
        t_ucode cw;
        case (step)
            S_IDLE:    cw = '{sha1he_pkg::OP_WAIT,   sha1he_pkg::C_IN_ACC,   S_ABSORB, S_IDLE};
            S_ABSORB:  cw = '{sha1he_pkg::OP_ABSORB, sha1he_pkg::C_FULL,     S_LOAD,   S_RT_LAST};
            S_RT_LAST: cw = '{sha1he_pkg::OP_NOP,    sha1he_pkg::C_NOT_LAST, S_IDLE,   S_RT_LEN};
            S_RT_LEN:  cw = '{sha1he_pkg::OP_NOP,    sha1he_pkg::C_LEN_DONE, S_EMIT,   S_RT_PAD};
            S_RT_PAD:  cw = '{sha1he_pkg::OP_NOP,    sha1he_pkg::C_PAD_DONE, S_LEN,    S_PAD};
            S_PAD:     cw = '{sha1he_pkg::OP_PAD,    sha1he_pkg::C_ALWAYS,   S_LOAD,   S_LOAD};
            S_LEN:     cw = '{sha1he_pkg::OP_LEN,    sha1he_pkg::C_ALWAYS,   S_LOAD,   S_LOAD};
            S_LOAD:    cw = '{sha1he_pkg::OP_LOAD,   sha1he_pkg::C_ALWAYS,   S_ROUND,  S_ROUND};
            S_ROUND:   cw = '{sha1he_pkg::OP_ROUND,  sha1he_pkg::C_RND_MORE, S_ROUND,  S_FOLD};
            S_FOLD:    cw = '{sha1he_pkg::OP_FOLD,   sha1he_pkg::C_ALWAYS,   S_RT_MORE, S_RT_MORE};
            S_RT_MORE: cw = '{sha1he_pkg::OP_NOP,    sha1he_pkg::C_MORE,     S_ABSORB, S_RT_LAST};
            S_EMIT:    cw = '{sha1he_pkg::OP_EMIT,   sha1he_pkg::C_ALWAYS,   S_DRAIN,  S_DRAIN};
            S_DRAIN:   cw = '{sha1he_pkg::OP_DRAIN,  sha1he_pkg::C_OUT_ACC,  S_NEXTW,  S_DRAIN};
            S_NEXTW:   cw = '{sha1he_pkg::OP_NEXTW,  sha1he_pkg::C_IDX_MORE, S_EMIT,   S_FINISH};
            S_FINISH:  cw = '{sha1he_pkg::OP_REINIT, sha1he_pkg::C_ALWAYS,   S_IDLE,   S_IDLE};
            default:   cw = '{sha1he_pkg::OP_NOP,    sha1he_pkg::C_ALWAYS,   S_IDLE,   S_IDLE};
        endcase
        return cw;
    endfunction

    logic [3:0] r_step;
    logic [3:0] n_step;
    t_ucode     cw;
    logic       take;

    assign cw   = ucode_rom(r_step);
    assign o_op = cw.op;

    // Jump condition select
    always_comb begin
        case (cw.cond)
            sha1he_pkg::C_ALWAYS:   take = 1'b1;
            sha1he_pkg::C_IN_ACC:   take = i_flags.in_acc;
            sha1he_pkg::C_FULL:     take = i_flags.full;
            sha1he_pkg::C_NOT_LAST: take = i_flags.not_last;
            sha1he_pkg::C_LEN_DONE: take = i_flags.len_done;
            sha1he_pkg::C_PAD_DONE: take = i_flags.pad_done;
            sha1he_pkg::C_RND_MORE: take = i_flags.rnd_more;
            sha1he_pkg::C_MORE:     take = i_flags.more;
            sha1he_pkg::C_OUT_ACC:  take = i_flags.out_acc;
            sha1he_pkg::C_IDX_MORE: take = i_flags.idx_more;
            default:                take = 1'b1;
        endcase
        n_step = take ? cw.jmp : cw.nxt;
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- dv/sha1_hash_engine_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// sha1_hash_engine_tb
// Self-checking bench for the streaming SHA-1 engine. Messages are cut into
// beats of 0..7 byte counts and pushed through the input channel. A built-in
// SHA-1 predictor computes the five digest words for each accepted message,
// and the output monitor checks them in order. Both channels see random
// idle and stall gaps, mostly short with a few long ones.
// ============================================================================
module sha1_hash_engine_tb;

    localparam int N_ITEMS = 500;

    typedef struct {
        sha1he_pkg::t_in_beat beat;
        int                   gap;
        logic                 hold;
    } t_tb_item;

    // Clock, reset and DUT channels
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    sha1he_pkg::t_in_beat  in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    sha1he_pkg::t_out_beat out_beat;

    // Bench bookkeeping
    t_tb_item              drv_q [$];
    sha1he_pkg::t_out_beat exp_q [$];
    logic                  in_took    = 1'b0;
    int                    gap_left   = 0;
    int                    stall_left = 0;
    int                    sent       = 0;
    int                    errors     = 0;

    // Predictor state
    logic [31:0] m_h   [5];
    logic [31:0] m_blk [16];
    logic [63:0] m_bits;

    sha1_hash_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic model_reset();
        for (int i = 0; i < 5; i++) begin
            m_h[i] = sha1he_pkg::H_INIT[i];
        end
        for (int i = 0; i < 16; i++) begin
            m_blk[i] = 32'h0;
        end
        m_bits = 64'd0;
    endtask

    // One 80-round compression of the current block
    task automatic model_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, tmp;
        a = m_h[0];
        b = m_h[1];
        c = m_h[2];
        d = m_h[3];
        e = m_h[4];
        for (int i = 0; i < 16; i++) begin
            w[i] = m_blk[i];
        end
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = rotl(w[(t + 13) & 15] ^ w[(t + 8) & 15] ^
                          w[(t + 2) & 15] ^ w[t & 15], 1);
                w[t & 15] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = sha1he_pkg::K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = sha1he_pkg::K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1he_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1he_pkg::K3;
            end
            tmp = rotl(a, 5) + f + e + k + wt;
            e   = d;
            d   = c;
            c   = rotl(b, 30);
            b   = a;
            a   = tmp;
        end
        m_h[0] = m_h[0] + a;
        m_h[1] = m_h[1] + b;
        m_h[2] = m_h[2] + c;
        m_h[3] = m_h[3] + d;
        m_h[4] = m_h[4] + e;
    endtask

    task automatic model_set_byte(input logic [5:0] pos, input logic [7:0] val);
        m_blk[pos[5:2]][8*(3-pos[1:0]) +: 8] = val;
    endtask

    task automatic model_absorb(input logic [7:0] val);
        logic [5:0] pos;
        pos = m_bits[8:3];
        model_set_byte(pos, val);
        m_bits = m_bits + 64'd8;
        if (pos == 6'd63) begin
            model_compress();
        end
    endtask

    // Predict the results of one accepted input beat
    task automatic model_step(input sha1he_pkg::t_in_beat beat);
        int                    n;
        int                    p;
        sha1he_pkg::t_out_beat ob;
        n = (beat.byte_count > sha1he_pkg::MAX_BYTES) ?
            int'(sha1he_pkg::MAX_BYTES) : int'(beat.byte_count);
        for (int i = 0; i < n; i++) begin
            model_absorb(beat.data_word[31-8*i -: 8]);
        end
        if (beat.last_in) begin
            p = int'(m_bits[8:3]);
            model_set_byte(6'(p), sha1he_pkg::PAD_BYTE);
            p++;
            if (p > 56) begin
                while (p < 64) begin
                    model_set_byte(6'(p), 8'h00);
                    p++;
                end
                model_compress();
                p = 0;
            end
            while (p < 56) begin
                model_set_byte(6'(p), 8'h00);
                p++;
            end
            m_blk[14] = m_bits[63:32];
            m_blk[15] = m_bits[31:0];
            model_compress();
            for (int i = 0; i < 5; i++) begin
                ob.digest_word = m_h[i];
                ob.word_index  = 3'(i);
                ob.last_out    = (3'(i) == sha1he_pkg::DIGEST_LAST);
                exp_q.push_back(ob);
            end
            for (int i = 0; i < 5; i++) begin
                m_h[i] = sha1he_pkg::H_INIT[i];
            end
            m_bits = 64'd0;
        end
    endtask

    // Queue one input beat with a random idle gap after it
    task automatic add_item(input logic [31:0] data, input logic [2:0] cnt,
                            input logic last, input logic hold);
        t_tb_item it;
        int       r;
        it.beat.data_word  = data;
        it.beat.byte_count = cnt;
        it.beat.last_in    = last;
        it.hold            = hold;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            it.gap = 0;
        end else if (r < 95) begin
            it.gap = $urandom_range(1, 3);
        end else begin
            it.gap = $urandom_range(10, 40);
        end
        drv_q.push_back(it);
    endtask

    // Input driver: new beat at the falling edge once the last one is taken
    always @(negedge clk) begin : in_drv
        t_tb_item cur;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!in_valid || in_took) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (drv_q.size() > 0 &&
                         !(drv_q[0].hold && exp_q.size() != 0)) begin
                cur = drv_q.pop_front();
                in_beat  <= cur.beat;
                in_valid <= 1'b1;
                gap_left <= cur.gap;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: mostly short bursts, a few long ones
    always @(negedge clk) begin : out_drv
        int r;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                out_stall <= 1'b0;
            end else if (r < 95) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(20, 60);
            end
        end
    end

    // Monitor: predict on each input beat, check each output beat
    always @(posedge clk) begin : mon
        sha1he_pkg::t_out_beat exp_beat;
        if (!rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                model_step(in_beat);
                sent++;
            end
            if (out_valid && !out_stall) begin
                if (exp_q.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t: unexpected beat word=%h idx=%0d last=%b", $realtime,
                                 out_beat.digest_word, out_beat.word_index,
                                 out_beat.last_out);
                    end
                    errors++;
                end else begin
                    exp_beat = exp_q.pop_front();
                    if (out_beat !== exp_beat) begin
                        if (errors < 10) begin
                            $display("%0t: mismatch exp word=%h idx=%0d last=%b",
                                     $realtime, exp_beat.digest_word,
                                     exp_beat.word_index, exp_beat.last_out);
                            $display("%0t:          got word=%h idx=%0d last=%b",
                                     $realtime, out_beat.digest_word,
                                     out_beat.word_index, out_beat.last_out);
                        end
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin : stim
        int         total;
        int         msg;
        int         kind;
        int         nbeats;
        int         nbytes;
        logic       hold;
        logic       zero_tail;
        logic [2:0] cnt;
        msg = 0;
        model_reset();
        while (drv_q.size() < N_ITEMS) begin
            kind = $urandom_range(0, 99);
            hold = (msg == 2) || ($urandom_range(0, 9) == 0);
            if (kind < 8) begin
                // empty message
                add_item($urandom(), 3'd0, 1'b1, hold);
            end else if (kind < 25) begin
                // lengths around the padding and block boundaries
                case ($urandom_range(0, 7))
                    0:       nbytes = 55;
                    1:       nbytes = 56;
                    2:       nbytes = 63;
                    3:       nbytes = 64;
                    4:       nbytes = 119;
                    5:       nbytes = 120;
                    6:       nbytes = 127;
                    default: nbytes = 128;
                endcase
                zero_tail = 1'($urandom_range(0, 1));
                if (zero_tail) begin
                    while (nbytes > 0) begin
                        cnt = (nbytes >= 4) ? 3'd4 : 3'(nbytes);
                        add_item($urandom(), cnt, 1'b0, hold);
                        hold   = 1'b0;
                        nbytes = nbytes - int'(cnt);
                    end
                    add_item($urandom(), 3'd0, 1'b1, hold);
                end else begin
                    while (nbytes > 4) begin
                        add_item($urandom(), 3'd4, 1'b0, hold);
                        hold   = 1'b0;
                        nbytes = nbytes - 4;
                    end
                    add_item($urandom(), 3'(nbytes), 1'b1, hold);
                end
            end else begin
                // random beats, odd byte counts now and then
                nbeats = (kind < 90) ? $urandom_range(1, 30) : $urandom_range(40, 80);
                for (int i = 0; i < nbeats; i++) begin
                    cnt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                    add_item($urandom(), cnt, (i == nbeats - 1), hold);
                    hold = 1'b0;
                end
            end
            msg++;
        end
        total = drv_q.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sent < total || exp_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
